FILE: hdl/mct_pkg.sv
// types, constants and table lookups shared by the marching cubes triangulator
package mct_pkg;

    // one cell waiting between the classifier and the vertex engine
    typedef struct packed {
        logic [7:0]        cx;
        logic [7:0]        cy;
        logic [7:0]        cz;
        logic [7:0][15:0]  corner;
        logic [7:0]        cube;
        logic [3:0]        len;
    } cell_item_t;

    // register indexes of the configuration port
    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] REG_STEP_X   = 3'd3;
    localparam logic [2:0] REG_STEP_Y   = 3'd4;
    localparam logic [2:0] REG_STEP_Z   = 3'd5;

    localparam logic [31:0] STEP_RESET = 32'h0001_0000;

    // triangle lists per cube index, one ascii hex digit per edge, right aligned
    localparam logic [119:0] TRI_LIST [256] = '{
"","083","019","183981","12a","08312a","92a029","2832a8a98",
"3b2","0b28b0","19023b","1b219b98b","3a1ba3","0a108a8ba","3903b9ba9","98aa8b",
"478","430734","019847","419471731","12a847","34730412a","92a902847","2a9297273794",
"8473b2","b47b24204","90184723b","47b94b9b2921","3a13ba784","1ba14b1047b4","47890b9bab03",
"47b4b99ba",
"954","954083","054150","854835315","12a954","30812a495","52a542402","2a5325354348",
"95423b","0b208b495","05401523b","21525828b485","a3ba13954","4950818a18ba","54050b5bab03",
"54858aa8b",
"978579","930953573","078017157","153357","978957a12","a12950530573","802825857a52",
"2a5253357",
"7957893b2","95797292027b","23b018178157","b21b17715","958857a13a3b","5705097b010aba0",
"ba0b03a50807570","ba57b5",
"a65","0835a6","9015a6","1831985a6","165261","165126308","965906026","598582526328",
"23ba65","b08b20a65","01923b5a6","5a61929b298b","63b653513","08b0b50515b6","3b6036065059",
"65969bb98",
"5a6478","43047365a","1905a6847","a65197173794","612651478","125526304347","847905065026",
"739794329596269",
"3b2784a65","5a647242027b","01947823b5a6","9219b294b7b45a6","8473b53515b6",
"51b5b610b7b404b","059065036b63847","65969b4797b9",
"a4964a","4a649a083","a01a60640","83181686461a","149124264","308129249264","024426",
"832824426",
"a49a64b23","08228b49a4a6","3b201606461a","64161a48121b8b1","964936913b63",
"8b1810b61914641","3b6360064","648b68",
"7a678a89a","0730a709a67a","a671a7178180","a67a71173","126168189867","269291679093739",
"780706602","732672",
"23ba68a89867","20727b09767a9a7","1801781a767a23b","b21b17a61671","896867916b63136",
"091b67","7807063b0b60","7b6",
"76b","308b76","019b76","819831b76","a126b7","12a3086b7","2902a96b7","6b72a3a83a98",
"723627","708760620","276237019","162186198876","a76a17137","a7617a187108","03707a0a96a7",
"76a7a88a9",
"684b86","36b306046","86b846901","946963931b36","6846b82a1","12a30b06b046","4b846b0292a9",
"a93a32943b36463",
"823842462","042462","190234246438","194142246","8138618466a1","a10a06604",
"4634386a3039a93","a946a4",
"49576b","083495b76","50154076b","b76834354315","954a1276b","6b712a083495","76b54a42a402",
"348354325a52b76",
"723762549","954086062687","362376150540","628687218485158","954a16176137",
"16a176107870954","40a4a503a6a737a","76a7a854a48a",
"6956b9b89","36b063056095","0b805b01556b","6b3635531","12a95b9b8b56","0b306b09656912a",
"b85b56805a52025","6b36352a3a53",
"589528562382","956960062","158180568382628","156216","13616a386569896","a10a06950560",
"03856a","a56",
"b5a75b","b5ab75830","5b75ab190","a75ab7981831","b12b71751","08312717572b","9759279022b7",
"75272b592328982",
"25a235375","820852875a25","9015a35373a2","982921872a25752","135375","087071175",
"903935537","987597",
"5845a8ab8","5045b05abb30","01984a8aba45","ab4a45b34941314","2512852b8458",
"04b0b345b2b151b","0250592b5458b85","9452b3",
"25a352345384","5a2524420","3a235a385458019","5a2524192942","845853351","045105",
"845853905035","945",
"4b749b9ab","0834979b79ab","1ab1b414074b","3143481a474bab4","4b79b492b912",
"9749b791b2b1083","b74b42240","b74b42834324",
"29a279237749","9a7974a27870207","37a3a274a1a040a","1a2874","491417713","491417081871",
"403743","487",
"9a8ab8","30939bb9a","01a0a88ab","31ab3a","12b1b99b8","30939b1292b9","02b80b","32b",
"23828aa89","9a2092","23828a0181a8","1a2","138918","091","038",""
    };

    // number of vertices listed for a cube index
    function automatic logic [3:0] tri_len(input logic [7:0] cube);
        logic [119:0] row;
        logic [3:0]   cnt;
        row = TRI_LIST[cube];
        cnt = '0;
        for (int i = 0; i < 15; i++) begin
            cnt = cnt + {3'd0, (row[8*i +: 8] != 8'd0)};
        end
        return cnt;
    endfunction

    // edge number of vertex n of a cube index with len vertices
    function automatic logic [3:0] tri_edge(input logic [7:0] cube, input logic [3:0] len,
                                            input logic [3:0] n);
        logic [119:0] row;
        logic [3:0]   idx;
        logic [7:0]   ch;
        logic [7:0]   e;
        row = TRI_LIST[cube];
        idx = len - 4'd1 - n;
        ch  = row[8*int'(idx) +: 8];
        if (ch >= 8'h61) begin
            e = ch - 8'h61 + 8'd10;
        end else begin
            e = ch - 8'h30;
        end
        return (e < 8'd12) ? e[3:0] : 4'd0;
    endfunction

    // corner offset as {z, y, x}
    function automatic logic [2:0] corner_off(input logic [2:0] c);
        logic [2:0] o;
        unique case (c)
            3'd0: o = 3'b000;
            3'd1: o = 3'b001;
            3'd2: o = 3'b011;
            3'd3: o = 3'b010;
            3'd4: o = 3'b100;
            3'd5: o = 3'b101;
            3'd6: o = 3'b111;
            default: o = 3'b110;
        endcase
        return o;
    endfunction

    // first end corner of an edge
    function automatic logic [2:0] edge_a(input logic [3:0] e);
        logic [2:0] c;
        unique case (e)
            4'd0: c = 3'd0;
            4'd1: c = 3'd1;
            4'd2: c = 3'd2;
            4'd3: c = 3'd3;
            4'd4: c = 3'd4;
            4'd5: c = 3'd5;
            4'd6: c = 3'd6;
            4'd7: c = 3'd7;
            4'd8: c = 3'd0;
            4'd9: c = 3'd1;
            4'd10: c = 3'd2;
            4'd11: c = 3'd3;
            default: c = 3'd0;
        endcase
        return c;
    endfunction

    // second end corner of an edge
    function automatic logic [2:0] edge_b(input logic [3:0] e);
        logic [2:0] c;
        unique case (e)
            4'd0: c = 3'd1;
            4'd1: c = 3'd2;
            4'd2: c = 3'd3;
            4'd3: c = 3'd0;
            4'd4: c = 3'd5;
            4'd5: c = 3'd6;
            4'd6: c = 3'd7;
            4'd7: c = 3'd4;
            4'd8: c = 3'd4;
            4'd9: c = 3'd5;
            4'd10: c = 3'd6;
            4'd11: c = 3'd7;
            default: c = 3'd1;
        endcase
        return c;
    endfunction

endpackage

FILE: hdl/mct_front.sv
// cell classifier and two-entry cell queue
module mct_front #(
    parameter int MAX_CELLS = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          cell_x,
    input  logic [7:0]          cell_y,
    input  logic [7:0]          cell_z,
    input  logic [7:0][15:0]    corners,
    output logic                q_valid,
    output mct_pkg::cell_item_t q_item,
    input  logic                q_pop
);
    import mct_pkg::*;

    cell_item_t q_mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    logic       accept;
    logic       keep;
    logic [7:0] cube;
    logic [3:0] len;
    logic       in_range;
    cell_item_t item;

    // sign index and vertex count of the incoming cell
    always_comb
    begin
        for (int i = 0; i < 8; i++) begin
            cube[i] = corners[i][15];
        end
        len      = tri_len(cube);
        in_range = (int'(cell_x) < MAX_CELLS) && (int'(cell_y) < MAX_CELLS)
                   && (int'(cell_z) < MAX_CELLS);
        keep     = in_range && (len != 4'd0);
        item.cx     = cell_x;
        item.cy     = cell_y;
        item.cz     = cell_z;
        item.corner = corners;
        item.cube   = cube;
        item.len    = len;
    end

    assign full    = (cnt_reg == 2'd2);
    assign accept  = push && !full;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = q_mem_reg[rd_ptr_reg];

    // queue pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ (accept && keep);
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        cnt_next    = cnt_reg + {1'b0, accept && keep} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (accept && keep) begin
            q_mem_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

FILE: hdl/mct_back.sv
// vertex engine: edge interpolation with a radix-16 divider and vertex output register
module mct_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [2:0][31:0]    origin,
    input  logic [2:0][31:0]    step,
    input  logic                q_valid,
    input  mct_pkg::cell_item_t q_item,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_take,
    output logic [2:0][31:0]    out_pos,
    output logic [31:0]         out_index,
    output logic [1:0]          out_corner,
    output logic                out_last
);
    import mct_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EDGE = 6'b000010,
        S_MUL  = 6'b000100,
        S_PRE  = 6'b001000,
        S_DIV  = 6'b010000,
        S_EMIT = 6'b100000
    } state_t;

    state_t          state_reg, state_next;
    cell_item_t      item_reg;
    logic [3:0]      n_reg;
    logic [1:0]      tc_reg;
    logic [2:0]      div_cnt_reg;
    logic [31:0]     count_reg;

    logic [15:0]     num_reg;
    logic [16:0]     den_reg;
    logic [1:0]      axis_reg;
    logic            dneg_reg;
    logic [2:0][8:0] coord_reg;
    logic [2:0][31:0] base_reg;
    logic [47:0]     mag_reg;
    logic            neg_reg;
    logic [16:0]     rem_reg;
    logic [31:0]     quo_reg;

    logic            out_valid_reg;
    logic [2:0][31:0] out_pos_reg;
    logic [31:0]     out_index_reg;
    logic [1:0]      out_corner_reg;
    logic            out_last_reg;

    // edge decode
    logic [3:0]  e;
    logic [2:0]  ca, cb, oa, ob, diff;
    logic [15:0] va, vb, ma, mb;
    logic [31:0] step_sel, step_mag;
    logic [48:0] dividend;
    logic [16:0] rem_d;
    logic [31:0] quo_d;
    logic [17:0] r18;
    logic [31:0] q_final;
    logic        emit_go;
    logic        last_v;

    always_comb
    begin
        e    = tri_edge(item_reg.cube, item_reg.len, n_reg);
        ca   = edge_a(e);
        cb   = edge_b(e);
        oa   = corner_off(ca);
        ob   = corner_off(cb);
        diff = oa ^ ob;
        va   = item_reg.corner[ca];
        vb   = item_reg.corner[cb];
        ma   = va[15] ? (16'd0 - va) : va;
        mb   = vb[15] ? (16'd0 - vb) : vb;
    end

    // multiplier operands and divider steps
    always_comb
    begin
        step_sel = step[axis_reg];
        step_mag = step_sel[31] ? (32'd0 - step_sel) : step_sel;
        dividend = {1'b0, mag_reg} + {32'd0, den_reg >> 1};
        rem_d    = rem_reg;
        quo_d    = quo_reg;
        r18      = '0;
        for (int i = 0; i < 4; i++) begin
            r18 = {rem_d, quo_d[31]};
            quo_d = {quo_d[30:0], (r18 >= {1'b0, den_reg})};
            if (r18 >= {1'b0, den_reg}) begin
                rem_d = 17'(r18 - {1'b0, den_reg});
            end else begin
                rem_d = r18[16:0];
            end
        end
        q_final = (den_reg == 17'd0) ? 32'd0 : quo_reg;
        last_v  = (n_reg == item_reg.len - 4'd1);
        emit_go = (state_reg == S_EMIT) && (!out_valid_reg || out_take);
        q_pop   = (state_reg == S_IDLE) && q_valid;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (q_valid) state_next = S_EDGE;
            S_EDGE: state_next = S_MUL;
            S_MUL:  state_next = S_PRE;
            S_PRE:  state_next = S_DIV;
            S_DIV:  if (div_cnt_reg == 3'd7) state_next = S_EMIT;
            S_EMIT: if (emit_go) state_next = last_v ? S_IDLE : S_EDGE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            n_reg         <= '0;
            tc_reg        <= '0;
            div_cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (out_take) begin
                out_valid_reg <= 1'b0;
            end
            if (q_pop) begin
                n_reg  <= '0;
                tc_reg <= '0;
            end
            if (state_reg == S_PRE) begin
                div_cnt_reg <= '0;
            end else if (state_reg == S_DIV) begin
                div_cnt_reg <= div_cnt_reg + 3'd1;
            end
            if (emit_go) begin
                out_valid_reg <= 1'b1;
                count_reg     <= count_reg + 32'd1;
                n_reg         <= n_reg + 4'd1;
                tc_reg        <= (tc_reg == 2'd2) ? 2'd0 : tc_reg + 2'd1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (q_pop) begin
            item_reg <= q_item;
        end
        if (state_reg == S_EDGE) begin
            num_reg      <= ma;
            den_reg      <= {1'b0, ma} + {1'b0, mb};
            axis_reg     <= diff[0] ? 2'd0 : (diff[1] ? 2'd1 : 2'd2);
            dneg_reg     <= |(oa & diff);
            coord_reg[0] <= {1'b0, item_reg.cx} + {8'd0, oa[0]};
            coord_reg[1] <= {1'b0, item_reg.cy} + {8'd0, oa[1]};
            coord_reg[2] <= {1'b0, item_reg.cz} + {8'd0, oa[2]};
        end
        if (state_reg == S_MUL) begin
            for (int i = 0; i < 3; i++) begin
                base_reg[i] <= origin[i] + 32'({23'd0, coord_reg[i]} * step[i]);
            end
            mag_reg <= {32'd0, num_reg} * {16'd0, step_mag};
            neg_reg <= dneg_reg ^ step_sel[31];
        end
        if (state_reg == S_PRE) begin
            rem_reg <= dividend[48:32];
            quo_reg <= dividend[31:0];
        end
        if (state_reg == S_DIV) begin
            rem_reg <= rem_d;
            quo_reg <= quo_d;
        end
        if (emit_go) begin
            for (int i = 0; i < 3; i++) begin
                if (2'(i) == axis_reg) begin
                    out_pos_reg[i] <= neg_reg ? (base_reg[i] - q_final)
                                              : (base_reg[i] + q_final);
                end else begin
                    out_pos_reg[i] <= base_reg[i];
                end
            end
            out_index_reg  <= count_reg;
            out_corner_reg <= tc_reg;
            out_last_reg   <= last_v;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_pos    = out_pos_reg;
    assign out_index  = out_index_reg;
    assign out_corner = out_corner_reg;
    assign out_last   = out_last_reg;

endmodule

FILE: hdl/marching_cubes_cell_triangulator.sv
// marching cubes cell triangulator: top level with configuration registers
// Input queue side: a cell word (cell_x/y/z, corner_0..7) is taken when push is
// high and full is low. A two-entry cell queue sits behind the classifier, so
// full rises only when two cells are waiting for the vertex engine.
// Output queue side: a vertex word is on pos_x/y/z, vertex_index,
// triangle_corner and last_of_cell while empty is low; pop takes it.
// Cells with an all-inside or all-outside sign index, or an index at or beyond
// MAX_CELLS, are dropped by the classifier and produce no word.
// Each vertex passes through the vertex engine steps edge decode, multiply,
// rounding add, the 4-bit-per-cycle divider and emit, in that order. A cell is
// fetched from the queue only when the engine is idle after its last vertex.
// When pop is held low the engine waits in its emit step with the finished
// vertex; the cell queue keeps accepting until it is full.
// Reset clears the queues, the vertex counter, origin to 0 and step to 1.0.
// Configuration goes through the APB port at byte address 4*i. The user must
// write it only while the block is idle; the block does not enforce this.
module marching_cubes_cell_triangulator #(
    parameter int MAX_CELLS = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         cell_x,
    input  logic [7:0]         cell_y,
    input  logic [7:0]         cell_z,
    input  logic signed [15:0] corner_0,
    input  logic signed [15:0] corner_1,
    input  logic signed [15:0] corner_2,
    input  logic signed [15:0] corner_3,
    input  logic signed [15:0] corner_4,
    input  logic signed [15:0] corner_5,
    input  logic signed [15:0] corner_6,
    input  logic signed [15:0] corner_7,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic [31:0]        vertex_index,
    output logic [1:0]         triangle_corner,
    output logic               last_of_cell
);
    import mct_pkg::*;

    logic [2:0][31:0] origin_reg;
    logic [2:0][31:0] step_reg;
    logic [2:0]       reg_idx;
    logic             wr_en;
    logic [7:0][15:0] corners;
    logic             q_valid;
    cell_item_t       q_item;
    logic             q_pop;
    logic             out_valid;
    logic [2:0][31:0] out_pos;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            origin_reg <= '0;
            step_reg   <= {STEP_RESET, STEP_RESET, STEP_RESET};
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ORIGIN_X: origin_reg[0] <= pwdata;
                REG_ORIGIN_Y: origin_reg[1] <= pwdata;
                REG_ORIGIN_Z: origin_reg[2] <= pwdata;
                REG_STEP_X:   step_reg[0]   <= pwdata;
                REG_STEP_Y:   step_reg[1]   <= pwdata;
                REG_STEP_Z:   step_reg[2]   <= pwdata;
                default: ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (reg_idx)
            REG_ORIGIN_X: prdata = origin_reg[0];
            REG_ORIGIN_Y: prdata = origin_reg[1];
            REG_ORIGIN_Z: prdata = origin_reg[2];
            REG_STEP_X:   prdata = step_reg[0];
            REG_STEP_Y:   prdata = step_reg[1];
            REG_STEP_Z:   prdata = step_reg[2];
            default:      prdata = 32'd0;
        endcase
    end

    assign corners = {corner_7, corner_6, corner_5, corner_4,
                      corner_3, corner_2, corner_1, corner_0};

    mct_front #(
        .MAX_CELLS (MAX_CELLS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .cell_x  (cell_x),
        .cell_y  (cell_y),
        .cell_z  (cell_z),
        .corners (corners),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    mct_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .origin     (origin_reg),
        .step       (step_reg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_take   (pop && out_valid),
        .out_pos    (out_pos),
        .out_index  (vertex_index),
        .out_corner (triangle_corner),
        .out_last   (last_of_cell)
    );

    assign empty = !out_valid;
    assign pos_x = out_pos[0];
    assign pos_y = out_pos[1];
    assign pos_z = out_pos[2];

endmodule
